// ===== rtl/servo_pulse_ramp_generator_unit_defines.svh =====
// assertion macros shared by the servo ramp generator rtl
`ifndef SERVO_PULSE_RAMP_GENERATOR_UNIT_DEFINES_SVH
`define SERVO_PULSE_RAMP_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk while out of reset
`define SRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk while out of reset
`define SRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/srg_pkg.sv =====
// constants, widths and shared types of the servo ramp generator
package srg_pkg;

  // field widths
  localparam int ANGLE_W = 8;
  localparam int DUR_W   = 16;
  localparam int PULSE_W = 12;

  // pulse mapping and tick period
  localparam int PULSE_SPAN = 2000;
  localparam int ANGLE_MAX  = 180;
  localparam int PULSE_MIN  = 500;
  localparam int PULSE_MAX  = PULSE_MIN + PULSE_SPAN;
  localparam int TICK_MS    = 10;

  // reciprocals for the constant divisions
  // angle*2000/180 == (angle*TGT_RECIP) >> TGT_SHIFT for angle up to 180
  localparam int TGT_RECIP  = 1456356;
  localparam int TGT_SHIFT  = 17;
  // duration/10 == (duration*TICK_RECIP) >> TICK_SHIFT over the full 16 bits
  localparam int TICK_RECIP = 52429;
  localparam int TICK_SHIFT = 19;

  // shared divider: dividend holds the distance magnitude, divisor the step count
  localparam int DIV_W = PULSE_W + 1;
  localparam int DSR_W = DUR_W;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // command codes
  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/srg_in_if.sv =====
// move/tick input channel
interface srg_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [srg_pkg::ANGLE_W-1:0]  angle_deg;
  logic [srg_pkg::DUR_W-1:0]    duration_ms;

  modport source (output valid, output cmd, output angle_deg, output duration_ms,
                  input ready);
  modport sink   (input valid, input cmd, input angle_deg, input duration_ms,
                  output ready);
endinterface

// ===== rtl/srg_out_if.sv =====
// pulse result channel
interface srg_out_if;
  logic                         valid;
  logic                         ready;
  logic [srg_pkg::PULSE_W-1:0]  pulse_us;
  logic                         ramp_last;

  modport source (output valid, output pulse_us, output ramp_last, input ready);
  modport sink   (input valid, input pulse_us, input ramp_last, output ready);
endinterface

// ===== rtl/servo_pulse_ramp_generator_unit.sv =====
// servo pulse ramp generator: sequencer around a shared serial divider
//
//  channel  dir  handshake       payload
//  in_if    in   valid/ready     cmd, angle_deg, duration_ms
//  out_if   out  valid/ready     pulse_us, ramp_last
//
// a tick beat runs through accept, step update and load of the output register;
//   a tick with no active ramp is accepted and dropped
// a move beat: target, step count (constant reciprocal multiplies), step size on
//   the serial divider, one bit per cycle, and first step, or a jump to the target
// in_if.ready is high only while the sequencer is idle
// a result waits in the output register; a stalled sink holds the next result
// synchronous active-low reset clears the ramp state; no pulse before first move
`include "servo_pulse_ramp_generator_unit_defines.svh"

module servo_pulse_ramp_generator_unit (
  input  logic       clk,
  input  logic       rst_n,
  srg_in_if.sink     in_if,
  srg_out_if.source  out_if
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_TGT  = 6'b000010,
    S_CNT  = 6'b000100,
    S_STEP = 6'b001000,
    S_ADV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  localparam int PW = srg_pkg::PULSE_W;

  state_t                       state_r, state_nxt;
  logic [PW-1:0]                cur_r, cur_nxt;
  logic [PW-1:0]                tgt_r, tgt_nxt;
  logic signed [PW-1:0]         step_r, step_nxt;
  logic                         has_pos_r, has_pos_nxt;
  logic                         active_r, active_nxt;
  logic [srg_pkg::DUR_W-1:0]    dur_r, dur_nxt;
  logic [srg_pkg::ANGLE_W-1:0]  ang_r, ang_nxt;
  logic [PW-1:0]                pend_pulse_r, pend_pulse_nxt;
  logic                         pend_last_r, pend_last_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [PW-1:0]                out_pulse_r, out_pulse_nxt;
  logic                         out_last_r, out_last_nxt;

  srg_pkg::div_req_t            div_req;
  srg_pkg::div_rsp_t            div_rsp;

  logic [srg_pkg::ANGLE_W-1:0]  angle_sat;
  logic signed [PW:0]           diff;
  logic [PW:0]                  diff_mag;
  logic signed [PW+1:0]         next_pos;
  logic signed [PW+1:0]         tgt_s;
  logic                         reached;
  logic [31:0]                  tgt_prod;
  logic [31:0]                  cnt_prod;
  logic [srg_pkg::DSR_W-1:0]    step_cnt;
  logic [PW-1:0]                tgt_new;
  logic [PW-1:0]                step_mag;

  srg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // angle saturation and signed distance to the target
  assign angle_sat = (in_if.angle_deg > srg_pkg::ANGLE_W'(srg_pkg::ANGLE_MAX)) ?
                     srg_pkg::ANGLE_W'(srg_pkg::ANGLE_MAX) : in_if.angle_deg;
  assign diff      = $signed({1'b0, tgt_r}) - $signed({1'b0, cur_r});
  assign diff_mag  = diff[PW] ? (PW+1)'(-diff) : diff;

  // target pulse and step count by reciprocal multiply
  assign tgt_prod  = 32'(ang_r) * 32'(srg_pkg::TGT_RECIP);
  assign tgt_new   = PW'(tgt_prod >> srg_pkg::TGT_SHIFT) + PW'(srg_pkg::PULSE_MIN);
  assign cnt_prod  = 32'(dur_r) * 32'(srg_pkg::TICK_RECIP);
  assign step_cnt  = srg_pkg::DSR_W'(cnt_prod >> srg_pkg::TICK_SHIFT);
  assign step_mag  = PW'(div_rsp.quotient);

  // one step forward, finish on the target when reached or passed
  assign next_pos  = $signed({2'b00, cur_r}) + $signed({{2{step_r[PW-1]}}, step_r});
  assign tgt_s     = $signed({2'b00, tgt_r});
  assign reached   = step_r[PW-1] ? (next_pos <= tgt_s) : (next_pos >= tgt_s);

  assign in_if.ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    tgt_nxt        = tgt_r;
    step_nxt       = step_r;
    has_pos_nxt    = has_pos_r;
    active_nxt     = active_r;
    dur_nxt        = dur_r;
    ang_nxt        = ang_r;
    pend_pulse_nxt = pend_pulse_r;
    pend_last_nxt  = pend_last_r;
    out_valid_nxt  = out_valid_r;
    out_pulse_nxt  = out_pulse_r;
    out_last_nxt   = out_last_r;
    div_req        = '0;

    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          if (in_if.cmd == srg_pkg::CMD_TICK) begin
            if (active_r) begin
              state_nxt = S_ADV;
            end
          end else begin
            dur_nxt   = in_if.duration_ms;
            ang_nxt   = angle_sat;
            state_nxt = S_TGT;
          end
        end
      end
      S_TGT: begin
        tgt_nxt    = tgt_new;
        active_nxt = 1'b0;
        if (!has_pos_r) begin
          has_pos_nxt    = 1'b1;
          cur_nxt        = tgt_new;
          step_nxt       = '0;
          pend_pulse_nxt = tgt_new;
          pend_last_nxt  = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        if (step_cnt == '0) begin
          // short duration: jump to the target
          cur_nxt        = tgt_r;
          step_nxt       = '0;
          pend_pulse_nxt = tgt_r;
          pend_last_nxt  = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = srg_pkg::DIV_W'(diff_mag);
          div_req.divisor  = step_cnt;
          state_nxt        = S_STEP;
        end
      end
      S_STEP: begin
        if (div_rsp.done) begin
          if (step_mag == '0) begin
            // step truncated to nothing: jump to the target
            cur_nxt        = tgt_r;
            step_nxt       = '0;
            pend_pulse_nxt = tgt_r;
            pend_last_nxt  = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            step_nxt  = diff[PW] ? $signed(-step_mag) : $signed(step_mag);
            state_nxt = S_ADV;
          end
        end
      end
      S_ADV: begin
        if (reached) begin
          cur_nxt        = tgt_r;
          active_nxt     = 1'b0;
          pend_pulse_nxt = tgt_r;
          pend_last_nxt  = 1'b1;
        end else begin
          cur_nxt        = PW'(next_pos);
          active_nxt     = 1'b1;
          pend_pulse_nxt = PW'(next_pos);
          pend_last_nxt  = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_pulse_nxt = pend_pulse_r;
          out_last_nxt  = pend_last_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      tgt_r       <= '0;
      step_r      <= '0;
      has_pos_r   <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      tgt_r       <= tgt_nxt;
      step_r      <= step_nxt;
      has_pos_r   <= has_pos_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dur_r        <= dur_nxt;
    ang_r        <= ang_nxt;
    pend_pulse_r <= pend_pulse_nxt;
    pend_last_r  <= pend_last_nxt;
    out_pulse_r  <= out_pulse_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.pulse_us  = out_pulse_r;
  assign out_if.ramp_last = out_last_r;

  // checks
  `SRG_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `SRG_ASSERT_NOW(a_last_ends_ramp, (state_r == S_EMIT) && pend_last_r, !active_r, "final beat with ramp still active")
  `SRG_ASSERT_NOW(a_pos_in_range, has_pos_r, (cur_r >= PW'(srg_pkg::PULSE_MIN)) && (cur_r <= PW'(srg_pkg::PULSE_MAX)), "position out of pulse range")
  `SRG_ASSERT_NEXT(a_emit_loads, (state_r == S_EMIT) && (!out_valid_r || out_if.ready), out_valid_r && (out_pulse_r == $past(pend_pulse_r)), "pending beat not loaded")

endmodule

// ===== rtl/srg_div.sv =====
// shared restoring divider, one quotient bit per cycle
module srg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  srg_pkg::div_req_t req,
  output srg_pkg::div_rsp_t rsp
);

  logic [srg_pkg::DIV_W-1:0] quo_r, quo_nxt;
  logic [srg_pkg::DSR_W-1:0] dsr_r, dsr_nxt;
  logic [srg_pkg::DSR_W-1:0] rem_r, rem_nxt;
  logic [srg_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  logic [srg_pkg::DSR_W:0]   trial;
  logic [srg_pkg::DSR_W:0]   trial_sub;
  logic                      fits;

  // trial subtract of the shifted remainder
  assign trial     = {rem_r, quo_r[srg_pkg::DIV_W-1]};
  assign trial_sub = trial - {1'b0, dsr_r};
  assign fits      = (trial >= {1'b0, dsr_r});

  always_comb begin
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = srg_pkg::CNT_W'(srg_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[srg_pkg::DSR_W-1:0] : trial[srg_pkg::DSR_W-1:0];
      quo_nxt = {quo_r[srg_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == srg_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
